// ===== hw/rtl/random_sample_multiset_core_defines.svh =====
// Assertion macros shared by the random sample multiset RTL.
// No dependencies; included by the top level.
`ifndef RANDOM_SAMPLE_MULTISET_CORE_DEFINES_SVH
`define RANDOM_SAMPLE_MULTISET_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is active.
`define RSM_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error("rsm assertion failed");

// Next-cycle implication, disabled while reset is active.
`define RSM_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error("rsm assertion failed");

`endif

// ===== hw/rtl/rsm_pkg.sv =====
// Package for the random sample multiset: payload structs, codes and
// the command/status structs between controller and datapath.
`timescale 1ns / 1ps
package rsm_pkg;

  localparam int CAPACITY_DEF   = 64;
  localparam int VALUE_BITS_DEF = 32;
  localparam int RANDOM_BITS    = 31;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_SAMPLE = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [1:0]             op;
    logic signed [31:0]     value;
    logic [RANDOM_BITS-1:0] random;
  } in_t;

  typedef struct packed {
    logic               flag;
    logic signed [31:0] sample_value;
    logic [1:0]         status;
    logic [6:0]         size;
  } out_t;

  typedef struct packed {
    logic load;
    logic scan_start;
    logic div_start;
    logic rd_last;
    logic rd_sample;
    logic ins_write;
    logic rm_write;
    logic ins_full;
    logic smp_empty;
    logic smp_capture;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       full;
    logic       empty;
    logic       scan_done;
    logic       div_done;
    logic       found;
  } sts_t;

endpackage

// ===== hw/rtl/rsm_dpath.sv =====
// Datapath of the random sample multiset: entry memories, scan counter,
// match counting, serial modulo unit and result registers. Uses rsm_pkg.
`timescale 1ns / 1ps
module rsm_dpath #(
  parameter int CAPACITY   = rsm_pkg::CAPACITY_DEF,
  parameter int VALUE_BITS = rsm_pkg::VALUE_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  rsm_pkg::in_t  in_data,
  input  rsm_pkg::cmd_t cmd,
  output rsm_pkg::sts_t sts,
  output rsm_pkg::out_t out_data
);
  import rsm_pkg::*;

  localparam int AW  = $clog2(CAPACITY);
  localparam int FW  = $clog2(CAPACITY + 1);
  localparam int DCW = $clog2(RANDOM_BITS + 1);

  logic [VALUE_BITS-1:0] mem_val  [CAPACITY];
  logic [AW-1:0]         mem_rank [CAPACITY];

  logic [VALUE_BITS-1:0]  rd_val_r;
  logic [AW-1:0]          rd_rank_r;
  logic [1:0]             op_r;
  logic [VALUE_BITS-1:0]  val_r;
  logic [RANDOM_BITS-1:0] dvd_r;
  logic [FW-1:0]          fill_r;
  logic [FW-1:0]          count_r;
  logic [AW-1:0]          slot_r;
  logic [AW-1:0]          best_r;
  logic [AW-1:0]          scan_idx_r;
  logic                   issuing_r;
  logic                   pend_r;
  logic [AW-1:0]          pend_addr_r;
  logic [FW-1:0]          rem_r;
  logic [DCW-1:0]         div_cnt_r;
  logic                   flag_r;
  logic [31:0]            sample_r;
  logic [1:0]             status_r;

  logic [VALUE_BITS+31:0] in_wide;
  logic [VALUE_BITS+31:0] rd_ext;
  logic [FW-1:0]          fill_m1;
  logic [AW-1:0]          last_addr;
  logic                   rd_en;
  logic [AW-1:0]          rd_addr;
  logic                   wr_en;
  logic [AW-1:0]          wr_addr;
  logic [VALUE_BITS-1:0]  wr_val;
  logic [AW-1:0]          wr_rank;
  logic                   match;
  logic [FW:0]            div_try;
  logic [FW:0]            div_diff;

  // Values keep their low VALUE_BITS bits, zero-filled above bit 31.
  assign in_wide   = {{VALUE_BITS{1'b0}}, in_data.value};
  assign rd_ext    = {{32{rd_val_r[VALUE_BITS-1]}}, rd_val_r};
  assign fill_m1   = fill_r - FW'(1);
  assign last_addr = fill_m1[AW-1:0];
  assign match     = pend_r && (rd_val_r == val_r);
  assign div_try   = {rem_r, dvd_r[RANDOM_BITS-1]};
  assign div_diff  = div_try - {1'b0, fill_r};

  always_comb begin
    rd_en   = issuing_r;
    rd_addr = scan_idx_r;
    if (cmd.rd_last) begin
      rd_en   = 1'b1;
      rd_addr = last_addr;
    end
    if (cmd.rd_sample) begin
      rd_en   = 1'b1;
      rd_addr = rem_r[AW-1:0];
    end
  end

  always_comb begin
    wr_en   = cmd.ins_write || cmd.rm_write;
    wr_addr = fill_r[AW-1:0];
    wr_val  = val_r;
    wr_rank = count_r[AW-1:0];
    if (cmd.rm_write) begin
      wr_addr = slot_r;
      wr_val  = rd_val_r;
      wr_rank = rd_rank_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_val[wr_addr]  <= wr_val;
      mem_rank[wr_addr] <= wr_rank;
    end
    if (rd_en) begin
      rd_val_r  <= mem_val[rd_addr];
      rd_rank_r <= mem_rank[rd_addr];
    end
  end

  // Control state: fill level, scan sequencing and the modulo counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r    <= '0;
      issuing_r <= 1'b0;
      pend_r    <= 1'b0;
      div_cnt_r <= '0;
    end else begin
      pend_r <= issuing_r;
      if (cmd.scan_start) begin
        issuing_r <= (fill_r != '0);
      end else if (issuing_r && (scan_idx_r == last_addr)) begin
        issuing_r <= 1'b0;
      end
      if (cmd.div_start) begin
        div_cnt_r <= DCW'(RANDOM_BITS);
      end else if (div_cnt_r != '0) begin
        div_cnt_r <= div_cnt_r - DCW'(1);
      end
      if (cmd.ins_write) begin
        fill_r <= fill_r + FW'(1);
      end else if (cmd.rm_write) begin
        fill_r <= fill_m1;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_addr_r <= scan_idx_r;
    if (cmd.load) begin
      op_r     <= in_data.op;
      val_r    <= in_wide[VALUE_BITS-1:0];
      dvd_r    <= in_data.random;
      flag_r   <= 1'b0;
      sample_r <= '0;
      status_r <= ST_OK;
    end
    if (cmd.scan_start) begin
      scan_idx_r <= '0;
      count_r    <= '0;
      best_r     <= '0;
      slot_r     <= '0;
    end else begin
      if (issuing_r) begin
        scan_idx_r <= scan_idx_r + AW'(1);
      end
      if (match) begin
        count_r <= count_r + FW'(1);
        // Ranks of one value are distinct, so the highest one marks the slot.
        if ((count_r == '0) || (rd_rank_r > best_r)) begin
          best_r <= rd_rank_r;
          slot_r <= pend_addr_r;
        end
      end
    end
    if (cmd.div_start) begin
      rem_r <= '0;
    end else if (div_cnt_r != '0) begin
      rem_r <= div_diff[FW] ? div_try[FW-1:0] : div_diff[FW-1:0];
      dvd_r <= {dvd_r[RANDOM_BITS-2:0], 1'b0};
    end
    if (cmd.ins_write) begin
      flag_r <= (count_r == '0);
    end
    if (cmd.rm_write) begin
      flag_r <= 1'b1;
    end
    if (cmd.ins_full) begin
      status_r <= ST_FULL;
    end
    if (cmd.smp_empty) begin
      status_r <= ST_EMPTY;
    end
    if (cmd.smp_capture) begin
      sample_r <= rd_ext[31:0];
    end
  end

  assign sts.op        = op_r;
  assign sts.full      = (fill_r == FW'(CAPACITY));
  assign sts.empty     = (fill_r == '0);
  assign sts.scan_done = !issuing_r && !pend_r;
  assign sts.div_done  = (div_cnt_r == '0);
  assign sts.found     = (count_r != '0);

  assign out_data.flag         = flag_r;
  assign out_data.sample_value = sample_r;
  assign out_data.status       = status_r;
  assign out_data.size         = 7'(fill_r);

endmodule

// ===== hw/rtl/rsm_ctrl.sv =====
// Controller state machine of the random sample multiset.
// Drives datapath commands from rsm_pkg::cmd_t; uses rsm_pkg.
`timescale 1ns / 1ps
module rsm_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  rsm_pkg::sts_t sts,
  output rsm_pkg::cmd_t cmd,
  output logic          busy,
  output logic          out_valid
);
  import rsm_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_DISPATCH, S_SCAN, S_RM_WAIT, S_DIV, S_SMP_WAIT, S_RESP
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r, out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (sts.op)
          OP_INSERT: begin
            if (sts.full) begin
              cmd.ins_full = 1'b1;
              state_nxt    = S_RESP;
            end else begin
              cmd.scan_start = 1'b1;
              state_nxt      = S_SCAN;
            end
          end
          OP_REMOVE: begin
            cmd.scan_start = 1'b1;
            state_nxt      = S_SCAN;
          end
          OP_SAMPLE: begin
            if (sts.empty) begin
              cmd.smp_empty = 1'b1;
              state_nxt     = S_RESP;
            end else begin
              cmd.div_start = 1'b1;
              state_nxt     = S_DIV;
            end
          end
          default: state_nxt = S_RESP;
        endcase
      end
      S_SCAN: begin
        if (sts.scan_done) begin
          if (sts.op == OP_INSERT) begin
            cmd.ins_write = 1'b1;
            state_nxt     = S_RESP;
          end else if (sts.found) begin
            cmd.rd_last = 1'b1;
            state_nxt   = S_RM_WAIT;
          end else begin
            state_nxt = S_RESP;
          end
        end
      end
      S_RM_WAIT: begin
        cmd.rm_write = 1'b1;
        state_nxt    = S_RESP;
      end
      S_DIV: begin
        if (sts.div_done) begin
          cmd.rd_sample = 1'b1;
          state_nxt     = S_SMP_WAIT;
        end
      end
      S_SMP_WAIT: begin
        cmd.smp_capture = 1'b1;
        state_nxt       = S_RESP;
      end
      S_RESP: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      busy_r      <= (state_nxt != S_IDLE);
      out_valid_r <= (state_nxt == S_RESP);
    end
  end

  assign busy      = busy_r;
  assign out_valid = out_valid_r;

endmodule

// ===== hw/rtl/random_sample_multiset_core.sv =====
// Random sample multiset core: insert, remove and random sample of entries.
// Insert and remove scan the stored entries with one read per cycle; sample runs a
// one-bit-per-cycle modulo. The next request is taken in the cycle after the result.
// Synchronous active-low reset empties the set; memory contents are not cleared.
// The result shows for one cycle with out_valid; the receiver cannot stall.
`timescale 1ns / 1ps
`include "random_sample_multiset_core_defines.svh"
module random_sample_multiset_core #(
  parameter int CAPACITY   = rsm_pkg::CAPACITY_DEF,
  parameter int VALUE_BITS = rsm_pkg::VALUE_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  rsm_pkg::in_t  in_data,
  output logic          out_valid,
  output rsm_pkg::out_t out_data
);
  import rsm_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic accept;

  assign accept = start && !busy;

  rsm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (accept),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  rsm_dpath #(
    .CAPACITY   (CAPACITY),
    .VALUE_BITS (VALUE_BITS)
  ) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

  `RSM_ASSERT_NXT(a_single_result, clk, rst_n, out_valid, !out_valid)
  `RSM_ASSERT_NXT(a_busy_after_accept, clk, rst_n, accept, busy)
  `RSM_ASSERT_IMP(a_result_while_busy, clk, rst_n, out_valid, busy)
  `RSM_ASSERT_IMP(a_flag_only_ok, clk, rst_n, out_valid && out_data.flag, out_data.status == ST_OK)

endmodule

// ===== tb/tb_random_sample_multiset_core.sv =====
// Self-checking testbench for random_sample_multiset_core: directed table, then random requests.
// Depends on rsm_pkg and the core RTL; predicts every result with a local model of the multiset.
`timescale 1ns / 1ps
module tb_random_sample_multiset_core;
  import rsm_pkg::*;

  localparam int CAP = 64;
  localparam int N_RANDOM = 320;
  localparam longint CYCLE_LIMIT = 400000;
  localparam logic [1:0] OP_NOP = 2'd3;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  in_t in_data;
  logic out_valid;
  out_t out_data;

  random_sample_multiset_core u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_data(in_data), .out_valid(out_valid), .out_data(out_data)
  );

  // Local copy of the multiset.
  logic [31:0] set_value [CAP];
  logic [5:0] set_rank [CAP];
  int unsigned set_fill;

  out_t pending_results [$];
  int unsigned fail_count;
  longint cycle_count;

  typedef struct {
    in_t req;
    bit has_known;
    out_t known;
  } dir_row_t;

  dir_row_t dir_rows [$];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic out_t multiset_apply(in_t req);
    out_t res;
    int unsigned n;
    int unsigned slot;
    int unsigned last;
    res = '0;
    n = 0;
    for (int i = 0; i < set_fill; i++) if (set_value[i] == req.value) n++;
    case (req.op)
      OP_INSERT: begin
        if (set_fill >= CAP) begin
          res.status = ST_FULL;
        end else begin
          res.flag = (n == 0);
          set_value[set_fill] = req.value;
          set_rank[set_fill] = n[5:0];
          set_fill++;
        end
      end
      OP_REMOVE: begin
        if (n != 0) begin
          slot = 0;
          last = set_fill - 1;
          for (int i = 0; i < set_fill; i++)
            if (set_value[i] == req.value && set_rank[i] == 6'(n - 1)) slot = i;
          set_value[slot] = set_value[last];
          set_rank[slot] = set_rank[last];
          set_fill = last;
          res.flag = 1'b1;
        end
      end
      OP_SAMPLE: begin
        if (set_fill == 0) res.status = ST_EMPTY;
        else res.sample_value = set_value[32'(req.random) % set_fill];
      end
      default: ;
    endcase
    res.size = set_fill[6:0];
    return res;
  endfunction

  // Result checking at the rising edge.
  always @(posedge clk) begin
    out_t want;
    if (rst_n) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("[random_sample_multiset_core] ERROR");
        $finish;
      end
      if (out_valid) begin
        if (pending_results.size() == 0) begin
          $error("result with no request outstanding: %p", out_data);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          if (out_data.flag !== want.flag) begin
            $error("flag: expected %0d, got %0d", want.flag, out_data.flag);
            fail_count++;
          end
          if (out_data.sample_value !== want.sample_value) begin
            $error("sample_value: expected %0d, got %0d", want.sample_value,
                   out_data.sample_value);
            fail_count++;
          end
          if (out_data.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_data.status);
            fail_count++;
          end
          if (out_data.size !== want.size) begin
            $error("size: expected %0d, got %0d", want.size, out_data.size);
            fail_count++;
          end
        end
      end
    end
  end

  // Drives one request at the falling edge and holds it until accepted. Start stays
  // high after acceptance; busy masks it until the next request or an idle gap.
  task automatic send_request(in_t req, bit has_known, out_t known, bit allow_gap);
    out_t res;
    if (allow_gap && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    start <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (busy) @(posedge clk);
    res = multiset_apply(req);
    if (has_known && res !== known) begin
      $error("directed row: table expects %p, model gives %p", known, res);
      fail_count++;
    end
    pending_results.insert(pending_results.size(), res);
    @(negedge clk);
  endtask

  function automatic in_t make_req(logic [1:0] op, logic [31:0] value, logic [30:0] rnd);
    in_t r;
    r.op = op;
    r.value = value;
    r.random = rnd;
    return r;
  endfunction

  function automatic out_t make_res(logic flag, logic [31:0] sv, logic [1:0] st, int sz);
    out_t r;
    r.flag = flag;
    r.sample_value = sv;
    r.status = st;
    r.size = sz[6:0];
    return r;
  endfunction

  function automatic void add_row(in_t req, bit has_known, out_t known);
    dir_row_t row;
    row.req = req;
    row.has_known = has_known;
    row.known = known;
    dir_rows.insert(dir_rows.size(), row);
  endfunction

  initial begin
    in_t req;
    logic [31:0] pool [8];
    int unsigned pick;
    int unsigned wait_cycles;

    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    set_fill = 0;
    fail_count = 0;
    cycle_count = 0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Empty-array cases, extremes and duplicates.
    add_row(make_req(OP_SAMPLE, 32'h0, 31'h7fffffff), 1'b1,
            make_res(1'b0, 32'h0, ST_EMPTY, 0));
    add_row(make_req(OP_REMOVE, 32'h5, 31'h0), 1'b1, make_res(1'b0, 32'h0, ST_OK, 0));
    add_row(make_req(OP_NOP, 32'hffffffff, 31'h7fffffff), 1'b1,
            make_res(1'b0, 32'h0, ST_OK, 0));
    add_row(make_req(OP_INSERT, 32'h80000000, 31'h0), 1'b1,
            make_res(1'b1, 32'h0, ST_OK, 1));
    add_row(make_req(OP_SAMPLE, 32'h0, 31'h7fffffff), 1'b1,
            make_res(1'b0, 32'h80000000, ST_OK, 1));
    add_row(make_req(OP_INSERT, 32'h7fffffff, 31'h0), 1'b1,
            make_res(1'b1, 32'h0, ST_OK, 2));
    add_row(make_req(OP_INSERT, 32'h7fffffff, 31'h0), 1'b1,
            make_res(1'b0, 32'h0, ST_OK, 3));
    add_row(make_req(OP_INSERT, 32'hffffffff, 31'h0), 1'b0, '0);
    add_row(make_req(OP_SAMPLE, 32'h0, 31'h7ffffffe), 1'b0, '0);
    add_row(make_req(OP_REMOVE, 32'h80000000, 31'h0), 1'b1,
            make_res(1'b1, 32'h0, ST_OK, 3));
    add_row(make_req(OP_REMOVE, 32'h7fffffff, 31'h0), 1'b0, '0);
    add_row(make_req(OP_SAMPLE, 32'h0, 31'h1), 1'b0, '0);
    add_row(make_req(OP_NOP, 32'h7fffffff, 31'h0), 1'b0, '0);
    add_row(make_req(OP_REMOVE, 32'h12345678, 31'h0), 1'b0, '0);
    foreach (dir_rows[i])
      send_request(dir_rows[i].req, dir_rows[i].has_known, dir_rows[i].known, 1'b1);

    // Fill to capacity, then try one more insert to hit the full status.
    while (set_fill < CAP)
      send_request(make_req(OP_INSERT, $urandom_range(0, 3), 31'($urandom)), 1'b0, '0, 1'b1);
    send_request(make_req(OP_INSERT, 32'h1, 31'h0), 1'b1,
                 make_res(1'b0, 32'h0, ST_FULL, CAP), 1'b1);
    send_request(make_req(OP_SAMPLE, 32'h0, 31'h7fffffff), 1'b0, '0, 1'b1);

    // Random part: values come from a small pool so duplicates and hits are common.
    for (int i = 0; i < 8; i++) pool[i] = $urandom;
    for (int i = 0; i < N_RANDOM; i++) begin
      req.random = 31'($urandom);
      req.value = ($urandom_range(0, 9) == 0) ? $urandom : pool[$urandom_range(0, 7)];
      pick = $urandom_range(0, 99);
      // Bias toward growth when small and shrinkage when large.
      if (pick < 2) req.op = OP_NOP;
      else if (pick < 30) req.op = OP_SAMPLE;
      else if (pick < 30 + ((set_fill < 32) ? 45 : 25)) req.op = OP_INSERT;
      else req.op = OP_REMOVE;
      send_request(req, 1'b0, '0, i < N_RANDOM - 40);
    end
    start <= 1'b0;

    wait_cycles = 0;
    while (pending_results.size() != 0 && wait_cycles < 2000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (100) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("[random_sample_multiset_core] OK");
    end else begin
      $display("[random_sample_multiset_core] ERROR");
    end
    $finish;
  end
endmodule
